FILE: hw/rtl/tpsp_pkg.sv
package tpsp_pkg;

  // Parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  // Record kinds
  typedef enum logic [2:0] {
    EV_VALUE  = 3'd0,
    EV_SEALED = 3'd1,
    EV_OPENED = 3'd2,
    EV_DONE   = 3'd3,
    EV_ERROR  = 3'd4
  } event_t;

  // Dense error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEADER    = 3'd1,
    ERR_UNKNOWN   = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_NEG_LEN   = 3'd4,
    ERR_BAD_COUNT = 3'd5,
    ERR_SPAN      = 3'd6,
    ERR_EMPTY     = 3'd7
  } err_t;

  // Type tags
  localparam logic [7:0] TYPE_S8     = 8'h01;
  localparam logic [7:0] TYPE_U8     = 8'h02;
  localparam logic [7:0] TYPE_S16    = 8'h03;
  localparam logic [7:0] TYPE_U16    = 8'h04;
  localparam logic [7:0] TYPE_S32    = 8'h05;
  localparam logic [7:0] TYPE_STRING = 8'h08;
  localparam logic [7:0] TYPE_GROUP  = 8'h20;

  localparam logic [7:0]  MAGIC_BYTE      = 8'hFF;
  localparam logic [19:0] MAX_ENTRIES_RST = 20'd1000000;

  // Records per byte and result queue sizing
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RCNT_W      = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [3:0]         type_code;
    logic [31:0]        raw_bits;
    logic signed [31:0] signed_value;
    logic [31:0]        group_index;
    logic [19:0]        decl_entries;
    logic [31:0]        value_total;
    logic [31:0]        string_offset;
    logic [2:0]         error_code;
    logic               last_of_run;
  } out_res_t;

  // Build one result record
  function automatic out_res_t mk_rec(
    input event_t      ev,
    input logic [3:0]  ty,
    input logic [31:0] raw,
    input logic [31:0] sv,
    input logic [31:0] gi,
    input logic [19:0] ec,
    input logic [31:0] vt,
    input logic [31:0] so,
    input err_t        err
  );
    out_res_t r;
    r.event_res     = ev;
    r.type_code     = ty;
    r.raw_bits      = raw;
    r.signed_value  = signed'(sv);
    r.group_index   = gi;
    r.decl_entries  = ec;
    r.value_total   = vt;
    r.string_offset = so;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/tpsp_parse.sv
module tpsp_parse
  import tpsp_pkg::*;
#(
  parameter int COUNT_WIDTH  = 32,
  parameter int HEADER_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  in_req_t             in_data,
  input  logic [19:0]         max_entries,
  output out_res_t            res_o [MAX_RES],
  output logic [RCNT_W-1:0]   res_cnt
);

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] HDR_END = CW'(HEADER_BYTES - 1);

  phase_t          phase_r, phase_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [31:0]     left_r, left_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   groups_r, groups_nxt;
  logic [CW-1:0]   span_r, span_nxt;
  logic [19:0]     gent_r, gent_nxt;
  logic [19:0]     ephase_r, ephase_nxt;

  err_t            err;
  logic            done;
  logic            val_emit;
  logic [31:0]     val_off;
  logic [31:0]     shifted;
  logic [31:0]     left_dec;
  logic [31:0]     sv;
  logic [19:0]     ephase_inc;
  logic [32:0]     pos_p1;
  logic [32:0]     off_diff;
  logic [RCNT_W-1:0] n;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Shared arithmetic for this byte
  assign shifted  = {shift_r[23:0], in_data.data_byte};
  assign left_dec = left_r - 32'd1;
  assign pos_p1   = 33'(pos_r) + 33'd1;
  assign off_diff = pos_p1 - {1'b0, shift_r};

  // Decode one byte and build its records in order
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    pos_nxt    = sat_inc(pos_r);
    total_nxt  = total_r;
    groups_nxt = groups_r;
    span_nxt   = span_r;
    gent_nxt   = gent_r;
    ephase_nxt = ephase_r;
    err        = ERR_NONE;
    done       = 1'b0;
    val_emit   = 1'b0;
    val_off    = '0;
    sv         = '0;
    ephase_inc = '0;
    n          = '0;
    res_o      = '{default: '0};

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r < CW'(2) && in_data.data_byte != MAGIC_BYTE) begin
          err = ERR_HEADER;
        end else if (pos_r >= HDR_END) begin
          phase_nxt = PH_TYPE;
          done      = in_data.last;
        end else if (in_data.last) begin
          err = ERR_HEADER;
        end
      end
      PH_TYPE: begin
        if ((in_data.data_byte >= TYPE_S8 && in_data.data_byte <= TYPE_STRING) ||
            in_data.data_byte == TYPE_GROUP) begin
          type_nxt  = in_data.data_byte;
          shift_nxt = '0;
          if (in_data.data_byte <= TYPE_U8) begin
            left_nxt = 32'd1;
          end else if (in_data.data_byte <= TYPE_U16) begin
            left_nxt = 32'd2;
          end else begin
            left_nxt = 32'd4;
          end
          phase_nxt = PH_PAYLOAD;
          if (in_data.last) begin
            err = ERR_TRUNCATED;
          end
        end else begin
          err = ERR_UNKNOWN;
        end
      end
      PH_PAYLOAD: begin
        shift_nxt = shifted;
        left_nxt  = left_dec;
        if (left_dec != 32'd0) begin
          if (in_data.last) begin
            err = ERR_TRUNCATED;
          end
        end else if (type_r == TYPE_GROUP) begin
          if (shifted == 32'd0 || shifted > {12'd0, max_entries}) begin
            err = ERR_BAD_COUNT;
          end else if (groups_r != '0 && (span_r == '0 || ephase_r != '0)) begin
            err = ERR_SPAN;
          end else begin
            // Seal the previous group, then open the new one
            if (groups_r != '0) begin
              res_o[n] = mk_rec(EV_SEALED, 4'd0, 32'd0, 32'd0, 32'(groups_r), gent_r,
                                32'(span_r), 32'd0, ERR_NONE);
              n = n + 1'b1;
            end
            groups_nxt = sat_inc(groups_r);
            gent_nxt   = shifted[19:0];
            span_nxt   = '0;
            ephase_nxt = '0;
            res_o[n] = mk_rec(EV_OPENED, 4'd0, 32'd0, 32'd0, 32'(groups_nxt), gent_nxt,
                              32'd0, 32'd0, ERR_NONE);
            n = n + 1'b1;
            phase_nxt = PH_TYPE;
            done      = in_data.last;
          end
        end else if (type_r == TYPE_STRING) begin
          if (shifted[31]) begin
            err = ERR_NEG_LEN;
          end else if (shifted == 32'd0) begin
            val_emit = 1'b1;
            val_off  = 32'(pos_nxt);
            done     = in_data.last;
          end else begin
            left_nxt  = shifted;
            phase_nxt = PH_SKIP;
            if (in_data.last) begin
              err = ERR_TRUNCATED;
            end
          end
        end else begin
          val_emit = 1'b1;
          done     = in_data.last;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          val_emit = 1'b1;
          val_off  = off_diff[32] ? 32'd0 : off_diff[31:0];
          done     = in_data.last;
        end else if (in_data.last) begin
          err = ERR_TRUNCATED;
        end
      end
      default: begin
      end
    endcase

    // Emit a finished value and advance the value counters
    if (val_emit) begin
      if (type_r == TYPE_S8) begin
        sv = {{24{shift_nxt[7]}}, shift_nxt[7:0]};
      end else if (type_r == TYPE_S16) begin
        sv = {{16{shift_nxt[15]}}, shift_nxt[15:0]};
      end else begin
        sv = shift_nxt;
      end
      res_o[n] = mk_rec(EV_VALUE, type_r[3:0], shift_nxt, sv, 32'(groups_r), gent_r, 32'd0,
                        (type_r == TYPE_STRING) ? val_off : 32'd0, ERR_NONE);
      n = n + 1'b1;
      total_nxt = sat_inc(total_r);
      if (groups_r != '0) begin
        span_nxt   = sat_inc(span_r);
        ephase_inc = ephase_r + 20'd1;
        ephase_nxt = (ephase_inc >= gent_r) ? 20'd0 : ephase_inc;
      end
      phase_nxt = PH_TYPE;
    end

    // Close the file on a clean last byte
    if (done && err == ERR_NONE) begin
      if (groups_nxt != '0) begin
        if (span_nxt == '0 || ephase_nxt != '0) begin
          err = ERR_SPAN;
        end else begin
          res_o[n] = mk_rec(EV_SEALED, 4'd0, 32'd0, 32'd0, 32'(groups_nxt), gent_nxt,
                            32'(span_nxt), 32'd0, ERR_NONE);
          n = n + 1'b1;
        end
      end
      if (err == ERR_NONE) begin
        if (total_nxt == '0 && groups_nxt == '0) begin
          err = ERR_EMPTY;
        end else begin
          res_o[n] = mk_rec(EV_DONE, 4'd0, 32'd0, 32'd0, 32'(groups_nxt), gent_nxt,
                            32'(total_nxt), 32'd0, ERR_NONE);
          n = n + 1'b1;
        end
      end
    end

    // Report an error once, then drop bytes until the last one
    if (err != ERR_NONE) begin
      res_o[n] = mk_rec(EV_ERROR, 4'd0, 32'd0, 32'd0, 32'(groups_nxt), gent_nxt,
                        32'd0, 32'd0, err);
      n = n + 1'b1;
      phase_nxt = PH_DRAIN;
    end

    // Return to the start of a new file
    if (in_data.last) begin
      phase_nxt  = PH_HEADER;
      type_nxt   = '0;
      shift_nxt  = '0;
      left_nxt   = '0;
      pos_nxt    = '0;
      total_nxt  = '0;
      groups_nxt = '0;
      span_nxt   = '0;
      gent_nxt   = '0;
      ephase_nxt = '0;
    end

    if (n != '0) begin
      res_o[n - 1'b1].last_of_run = 1'b1;
    end
    res_cnt = in_fire ? n : '0;
  end

  // Hold the parse state, advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      type_r   <= '0;
      shift_r  <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      total_r  <= '0;
      groups_r <= '0;
      span_r   <= '0;
      gent_r   <= '0;
      ephase_r <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      groups_r <= groups_nxt;
      span_r   <= span_nxt;
      gent_r   <= gent_nxt;
      ephase_r <= ephase_nxt;
    end
  end

endmodule

FILE: hw/rtl/typed_param_stream_parser.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    in_data   (in_req_t: one file byte + last flag)
// out_      out  out_valid / out_ready  out_data  (out_res_t: one record)
// cfg_      in   cfg_valid / cfg_ready  cfg_data  (max_entries, 20 bits)
//
// One byte is decoded per cycle while in_valid and in_ready are high; it yields
// zero to three records, which are written together into a four-entry record
// queue and leave one per cycle while out_ready is high. in_ready is high while
// at most one record is queued, so a byte giving one record each cycle streams at
// full rate; bytes giving several records stall input until the queue drains.
// Reset is synchronous and active low; there is no clearing pass.
// cfg_ready is always high.
module typed_param_stream_parser
  import tpsp_pkg::*;
#(
  parameter int COUNT_WIDTH  = 32,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_res_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  logic [19:0]       max_entries_r;
  out_res_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  out_res_t          res [MAX_RES];
  logic [RCNT_W-1:0] res_cnt;
  logic              in_fire;
  logic              pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = cnt_r <= QCNT_W'(QUEUE_DEPTH - MAX_RES);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + QCNT_W'(res_cnt) - QCNT_W'(pop);

  tpsp_parse #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_data     (in_data),
    .max_entries (max_entries_r),
    .res_o       (res),
    .res_cnt     (res_cnt)
  );

  // Hold the entry limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_entries_r <= cfg_data;
    end
  end

  // Write this byte's records into the queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RCNT_W'(i) < res_cnt) begin
        q_r[wr_ptr_r + QPTR_W'(i)] <= res[i];
      end
    end
  end

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(res_cnt);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: verif/typed_param_stream_parser_test.sv
`timescale 1ns / 1ps

module typed_param_stream_parser_test;
  import tpsp_pkg::*;

  localparam int HEADER_LEN = 8;
  localparam logic [7:0] TYPE_U32     = 8'h06;
  localparam logic [7:0] TYPE_FLOAT   = 8'h07;
  localparam logic [7:0] TYPE_UNKNOWN = 8'h09;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_res_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;

  typed_param_stream_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser state mirrored by the predictor
  phase_t      ps_phase = PH_HEADER;
  logic [7:0]  ps_type = '0;
  logic [31:0] ps_shift = '0;
  logic [31:0] ps_left = '0;
  logic [31:0] ps_pos = '0;
  logic [31:0] ps_values = '0;
  logic [31:0] ps_groups = '0;
  logic [31:0] ps_span = '0;
  logic [19:0] ps_entries = '0;
  logic [19:0] ps_ephase = '0;
  logic [19:0] limit_entries = MAX_ENTRIES_RST;

  out_res_t  step_recs[MAX_RES];
  int        step_n;
  out_res_t  expected_records[$];
  in_req_t   pending_bytes[$];
  logic [7:0] file_buf[$];
  int        queued_total = 0;
  int        failures = 0;
  bit        bursts_on = 1'b1;
  int        in_gap = 0;
  int        out_stall = 0;
  out_res_t  want_rec;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int payload_len(input logic [7:0] t);
    return (t <= TYPE_U8) ? 1 : (t <= TYPE_U16) ? 2 : 4;
  endfunction

  function automatic bit span_broken();
    return ps_groups != 0 && (ps_span == 0 || ps_ephase != 0);
  endfunction

  task automatic clear_stream();
    ps_phase   = PH_HEADER;
    ps_type    = '0;
    ps_shift   = '0;
    ps_left    = '0;
    ps_pos     = '0;
    ps_values  = '0;
    ps_groups  = '0;
    ps_span    = '0;
    ps_entries = '0;
    ps_ephase  = '0;
  endtask

  task automatic add_rec(input event_t ev, input logic [3:0] ty, input logic [31:0] raw,
                         input logic [31:0] sv, input logic [31:0] gi,
                         input logic [19:0] ec, input logic [31:0] vt,
                         input logic [31:0] so, input err_t err);
    out_res_t r;
    r.event_res     = ev;
    r.type_code     = ty;
    r.raw_bits      = raw;
    r.signed_value  = $signed(sv);
    r.group_index   = gi;
    r.decl_entries  = ec;
    r.value_total   = vt;
    r.string_offset = so;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    step_recs[step_n] = r;
    step_n++;
  endtask

  // Emit a value record and advance the group span counters
  task automatic add_value(input logic [31:0] offset);
    logic [31:0] raw;
    logic [31:0] sv;
    raw = ps_shift;
    sv  = raw;
    if (ps_type == TYPE_S8 && raw[7]) sv = raw | 32'hFFFF_FF00;
    if (ps_type == TYPE_S16 && raw[15]) sv = raw | 32'hFFFF_0000;
    ps_values = sat_inc(ps_values);
    if (ps_groups != 0) begin
      ps_span   = sat_inc(ps_span);
      ps_ephase = ps_ephase + 20'd1;
      if (ps_ephase >= ps_entries) ps_ephase = '0;
    end
    add_rec(EV_VALUE, ps_type[3:0], raw, sv, ps_groups, ps_entries, '0,
            (ps_type == TYPE_STRING) ? offset : 32'd0, ERR_NONE);
    ps_phase = PH_TYPE;
  endtask

  // Seal the open group and report the file outcome
  task automatic close_file(output err_t e);
    e = ERR_NONE;
    if (ps_groups != 0) begin
      if (span_broken()) begin
        e = ERR_SPAN;
        return;
      end
      add_rec(EV_SEALED, '0, '0, '0, ps_groups, ps_entries, ps_span, '0, ERR_NONE);
    end
    if (ps_values == 0 && ps_groups == 0) begin
      e = ERR_EMPTY;
      return;
    end
    add_rec(EV_DONE, '0, '0, '0, ps_groups, ps_entries, ps_values, '0, ERR_NONE);
  endtask

  // Work out the records that one accepted byte request gives
  task automatic decode_byte(input in_req_t req);
    logic [7:0]  b;
    logic        fin;
    logic [31:0] pos;
    logic [32:0] pos_next;
    logic [31:0] off;
    err_t        err;
    logic        done;
    out_res_t    r;
    b        = req.data_byte;
    fin      = req.last;
    pos      = ps_pos;
    pos_next = {1'b0, pos} + 33'd1;
    err      = ERR_NONE;
    done     = 1'b0;
    step_n   = 0;
    ps_pos   = sat_inc(pos);

    case (ps_phase)
      PH_HEADER: begin
        if (pos < 2 && b != MAGIC_BYTE) begin
          err = ERR_HEADER;
        end else if (pos_next >= HEADER_LEN) begin
          ps_phase = PH_TYPE;
          done = fin;
        end else if (fin) begin
          err = ERR_HEADER;
        end
      end
      PH_TYPE: begin
        if ((b >= TYPE_S8 && b <= TYPE_STRING) || b == TYPE_GROUP) begin
          ps_type  = b;
          ps_shift = '0;
          ps_left  = payload_len(b);
          ps_phase = PH_PAYLOAD;
          if (fin) err = ERR_TRUNCATED;
        end else begin
          err = ERR_UNKNOWN;
        end
      end
      PH_PAYLOAD: begin
        ps_shift = {ps_shift[23:0], b};
        ps_left  = ps_left - 32'd1;
        if (ps_left != 0) begin
          if (fin) err = ERR_TRUNCATED;
        end else if (ps_type == TYPE_GROUP) begin
          if (ps_shift == 0 || ps_shift > {12'd0, limit_entries}) begin
            err = ERR_BAD_COUNT;
          end else if (span_broken()) begin
            err = ERR_SPAN;
          end else begin
            if (ps_groups != 0)
              add_rec(EV_SEALED, '0, '0, '0, ps_groups, ps_entries, ps_span, '0, ERR_NONE);
            ps_groups  = sat_inc(ps_groups);
            ps_entries = ps_shift[19:0];
            ps_span    = '0;
            ps_ephase  = '0;
            add_rec(EV_OPENED, '0, '0, '0, ps_groups, ps_entries, '0, '0, ERR_NONE);
            ps_phase = PH_TYPE;
            done = fin;
          end
        end else if (ps_type == TYPE_STRING) begin
          if (ps_shift[31]) begin
            err = ERR_NEG_LEN;
          end else if (ps_shift == 0) begin
            add_value(ps_pos);
            done = fin;
          end else begin
            ps_left  = ps_shift;
            ps_phase = PH_SKIP;
            if (fin) err = ERR_TRUNCATED;
          end
        end else begin
          add_value('0);
          done = fin;
        end
      end
      PH_SKIP: begin
        ps_left = ps_left - 32'd1;
        if (ps_left == 0) begin
          off = (pos_next >= {1'b0, ps_shift}) ? 32'(pos_next - {1'b0, ps_shift}) : 32'd0;
          add_value(off);
          done = fin;
        end else if (fin) begin
          err = ERR_TRUNCATED;
        end
      end
      default: ;
    endcase

    if (done && err == ERR_NONE) close_file(err);
    if (err != ERR_NONE) begin
      add_rec(EV_ERROR, '0, '0, '0, ps_groups, ps_entries, '0, '0, err);
      ps_phase = PH_DRAIN;
    end
    if (fin) clear_stream();
    for (int i = 0; i < step_n; i++) begin
      r = step_recs[i];
      r.last_of_run = (i == step_n - 1);
      expected_records.push_back(r);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      failures++;
    end
  endtask

  task automatic compare_record(input out_res_t e, input out_res_t a);
    cmp_field("event_res", e.event_res, a.event_res);
    cmp_field("type_code", e.type_code, a.type_code);
    cmp_field("raw_bits", e.raw_bits, a.raw_bits);
    cmp_field("signed_value", e.signed_value, a.signed_value);
    cmp_field("group_index", e.group_index, a.group_index);
    cmp_field("decl_entries", e.decl_entries, a.decl_entries);
    cmp_field("value_total", e.value_total, a.value_total);
    cmp_field("string_offset", e.string_offset, a.string_offset);
    cmp_field("error_code", e.error_code, a.error_code);
    cmp_field("last_of_run", e.last_of_run, a.last_of_run);
  endtask

  // Byte driver: hold each request until taken, with random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      clear_stream();
    end else begin
      if (in_valid && in_ready) decode_byte(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0 && bursts_on) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
          if (bursts_on && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Record monitor: check each taken record, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: record with none expected, actual %p", $time, out_data);
          failures++;
        end else begin
          want_rec = expected_records.pop_front();
          compare_record(want_rec, out_data);
        end
      end
      if (out_stall > 0 && bursts_on) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // File building helpers
  task automatic send_file();
    in_req_t req;
    for (int i = 0; i < file_buf.size(); i++) begin
      req.data_byte = file_buf[i];
      req.last      = (i == file_buf.size() - 1);
      pending_bytes.push_back(req);
      queued_total++;
    end
    file_buf.delete();
  endtask

  task automatic put_header();
    file_buf.push_back(MAGIC_BYTE);
    file_buf.push_back(MAGIC_BYTE);
    repeat (HEADER_LEN - 2) file_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_item(input logic [7:0] t, input logic [31:0] payload);
    int n;
    n = payload_len(t);
    file_buf.push_back(t);
    for (int i = n - 1; i >= 0; i--) file_buf.push_back(payload[8*i +: 8]);
  endtask

  task automatic put_junk(input int n);
    repeat (n) file_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_string(input int len);
    put_item(TYPE_STRING, len);
    put_junk(len);
  endtask

  task automatic put_random_value();
    logic [7:0] t;
    t = 8'($urandom_range(TYPE_S8, TYPE_STRING));
    if (t == TYPE_STRING) put_string($urandom_range(0, 4));
    else put_item(t, $urandom());
  endtask

  // Mostly well-formed files with random content, some broken or noise
  task automatic gen_file();
    int mode;
    int cap;
    int cnt;
    int reps;
    int cut;
    mode = $urandom_range(0, 11);
    if (mode == 0) begin
      put_junk($urandom_range(1, 10));
    end else begin
      put_header();
      repeat ($urandom_range(0, 3)) put_random_value();
      cap = (limit_entries == 0) ? 3 : (limit_entries < 3) ? int'(limit_entries) : 3;
      repeat ($urandom_range(0, 3)) begin
        cnt  = $urandom_range(1, cap);
        reps = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        put_item(TYPE_GROUP, cnt);
        repeat (cnt * reps) put_random_value();
      end
      case (mode)
        1: begin
          cut = $urandom_range(1, file_buf.size() - 1);
          while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
        2: file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom_range(0, 255));
        3: put_random_value();
        default: ;
      endcase
    end
    send_file();
  endtask

  task automatic random_files(input int n);
    int target;
    target = queued_total + n;
    while (queued_total < target) gen_file();
  endtask

  // Wait until every request is taken and every record has come back
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write max_entries; call just after a rising edge
  task automatic write_limit(input logic [19:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_entries = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_files();
    // short header
    file_buf = '{MAGIC_BYTE, MAGIC_BYTE, 8'h00};
    send_file();
    // bad magic, then drop the rest up to the last byte
    file_buf = '{MAGIC_BYTE, 8'h00};
    put_junk(8);
    send_file();
    // empty file
    put_header();
    send_file();
    // flat list with every type and the field extremes
    put_header();
    put_item(TYPE_S8, 32'h80);
    put_item(TYPE_S8, 32'h7F);
    put_item(TYPE_U8, 32'hFF);
    put_item(TYPE_S16, 32'h8000);
    put_item(TYPE_U16, 32'hFFFF);
    put_item(TYPE_S32, 32'h8000_0000);
    put_item(TYPE_U32, 32'hFFFF_FFFF);
    put_item(TYPE_FLOAT, 32'h7F80_0000);
    put_string(0);
    put_string(3);
    send_file();
    // unknown type tags
    put_header();
    put_item(TYPE_UNKNOWN, 32'h0);
    send_file();
    put_header();
    put_item(TYPE_U8, 32'h01);
    file_buf.push_back(8'h00);
    send_file();
    // truncated inside a payload, at a type byte, and inside a string
    put_header();
    put_item(TYPE_S32, 32'h1234_5678);
    void'(file_buf.pop_back());
    void'(file_buf.pop_back());
    send_file();
    put_header();
    put_item(TYPE_U16, 32'hABCD);
    file_buf.push_back(TYPE_S16);
    send_file();
    put_header();
    put_item(TYPE_STRING, 32'd5);
    put_junk(2);
    send_file();
    // negative string length
    put_header();
    put_item(TYPE_STRING, 32'h8000_0000);
    put_junk(2);
    send_file();
    // flat list then two well-formed groups
    put_header();
    put_item(TYPE_S8, 32'hF0);
    put_item(TYPE_GROUP, 32'd2);
    repeat (4) put_random_value();
    put_item(TYPE_GROUP, 32'd1);
    put_string(2);
    send_file();
    // zero count and count far above the limit
    put_header();
    put_item(TYPE_GROUP, 32'd0);
    send_file();
    put_header();
    put_item(TYPE_GROUP, 32'hFFFF_FFFF);
    send_file();
    // span broken at a marker and at the end of the file
    put_header();
    put_item(TYPE_GROUP, 32'd2);
    put_random_value();
    put_item(TYPE_GROUP, 32'd1);
    put_random_value();
    send_file();
    put_header();
    put_item(TYPE_GROUP, 32'd3);
    send_file();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_files();
    random_files(50);

    // with a zero limit every marker fails
    settle();
    write_limit(20'd0);
    put_header();
    put_item(TYPE_GROUP, 32'd1);
    put_item(TYPE_S8, 32'h01);
    send_file();
    random_files(20);

    settle();
    write_limit(20'd1);
    random_files(40);

    // widest count the register allows
    settle();
    write_limit(20'hFFFFF);
    put_header();
    put_item(TYPE_GROUP, 32'h000F_FFFF);
    put_item(TYPE_U8, 32'h55);
    send_file();
    put_header();
    put_item(TYPE_GROUP, 32'h0010_0000);
    send_file();
    random_files(30);

    settle();
    write_limit(20'($urandom_range(2, 5)));
    random_files(30);

    // final stretch at full rate on both sides
    settle();
    bursts_on = 1'b0;
    write_limit(MAX_ENTRIES_RST);
    random_files(40);
    settle();

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
